// ===== sv/mbfs_pkg.sv =====
// Shared types, constants and the microcode program of the maze flood block.
`default_nettype none

package mbfs_pkg;

  // Default grid size
  localparam int ROWS_DEF = 16;
  localparam int COLS_DEF = 16;

  // Fixed field widths of the channels
  localparam int MODE_W = 2;
  localparam int POS_W  = 4;
  localparam int WALL_W = 4;
  localparam int FROM_W = 3;
  localparam int CNT_W  = 3;

  // Wall bit positions
  localparam int WB_N = 0;
  localparam int WB_E = 1;
  localparam int WB_S = 2;
  localparam int WB_W = 3;

  // Arrival move codes
  localparam logic [FROM_W-1:0] FROM_SEED  = 3'd0;
  localparam logic [FROM_W-1:0] FROM_NORTH = 3'd1;
  localparam logic [FROM_W-1:0] FROM_EAST  = 3'd2;
  localparam logic [FROM_W-1:0] FROM_SOUTH = 3'd3;
  localparam logic [FROM_W-1:0] FROM_WEST  = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_START = 2'd1,
    MODE_STEP  = 2'd2
  } mode_t;

  // Neighbor order of one expansion
  typedef enum logic [1:0] {
    DIR_S = 2'd0,
    DIR_E = 2'd1,
    DIR_N = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  typedef enum logic [2:0] {
    JMP_NEXT     = 3'd0,
    JMP_GOTO     = 3'd1,
    JMP_DISPATCH = 3'd2,
    JMP_IF_EMPTY = 3'd3,
    JMP_SWEEP    = 3'd4,
    JMP_EMIT     = 3'd5
  } jmp_t;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Microcode addresses
  localparam upc_t UA_IDLE  = 4'd0;
  localparam upc_t UA_LOAD  = 4'd1;
  localparam upc_t UA_CLR   = 4'd2;
  localparam upc_t UA_SEED  = 4'd3;
  localparam upc_t UA_STEP  = 4'd4;
  localparam upc_t UA_POP   = 4'd5;
  localparam upc_t UA_WALLS = 4'd6;
  localparam upc_t UA_EV_S  = 4'd7;
  localparam upc_t UA_EV_E  = 4'd8;
  localparam upc_t UA_EV_N  = 4'd9;
  localparam upc_t UA_EV_W  = 4'd10;
  localparam upc_t UA_EMIT  = 4'd11;

  typedef struct packed {
    logic sweep;      // clear one mark (and one wall cell while wiping)
    logic q_clr;      // empty the queue
    logic wr_load;    // write the loaded walls
    logic seed;       // queue the start cell
    logic pop;        // take the queue head as current cell
    logic lat_walls;  // capture the current cell's walls
    logic ev_en;      // evaluate one neighbor
    dir_t ev_dir;
    dir_t rd_dir;     // neighbor whose mark is read this step
    logic emit;       // load the result register
    jmp_t jmp;
    upc_t target;
  } mbfs_cw_t;

  typedef struct packed {
    mbfs_cw_t cw;
    logic     take;   // input request accepted this cycle
    logic     idle;
  } mbfs_ctl_t;

  typedef struct packed {
    logic q_empty;
    logic sweep_last;
    logic wipe;
    logic can_emit;
  } mbfs_stat_t;

  typedef struct packed {
    logic              expanded;
    logic [POS_W-1:0]  cell_row;
    logic [POS_W-1:0]  cell_col;
    logic [WALL_W-1:0] cell_walls;
    logic [FROM_W-1:0] arrived_from;
    logic [CNT_W-1:0]  pushed_count;
    logic              queue_empty;
  } mbfs_res_t;

  function automatic int dir_wall_bit(dir_t d);
    int b;
    case (d)
      DIR_S:   b = WB_S;
      DIR_E:   b = WB_E;
      DIR_N:   b = WB_N;
      default: b = WB_W;
    endcase
    return b;
  endfunction

  function automatic logic [FROM_W-1:0] dir_from(dir_t d);
    logic [FROM_W-1:0] f;
    case (d)
      DIR_S:   f = FROM_SOUTH;
      DIR_E:   f = FROM_EAST;
      DIR_N:   f = FROM_NORTH;
      default: f = FROM_WEST;
    endcase
    return f;
  endfunction

  // Control store
  function automatic mbfs_cw_t ucode_rom(upc_t a);
    mbfs_cw_t w;
    w        = '0;
    w.jmp    = JMP_NEXT;
    w.target = UA_IDLE;
    w.ev_dir = DIR_S;
    w.rd_dir = DIR_S;
    case (a)
      UA_IDLE: begin
        w.jmp = JMP_DISPATCH;
      end
      UA_LOAD: begin
        w.wr_load = 1'b1;
        w.jmp     = JMP_GOTO;
        w.target  = UA_EMIT;
      end
      UA_CLR: begin
        w.sweep = 1'b1;
        w.q_clr = 1'b1;
        w.jmp   = JMP_SWEEP;
      end
      UA_SEED: begin
        w.seed   = 1'b1;
        w.jmp    = JMP_GOTO;
        w.target = UA_EMIT;
      end
      UA_STEP: begin
        w.jmp    = JMP_IF_EMPTY;
        w.target = UA_EMIT;
      end
      UA_POP: begin
        w.pop = 1'b1;
      end
      UA_WALLS: begin
        w.lat_walls = 1'b1;
        w.rd_dir    = DIR_S;
      end
      UA_EV_S: begin
        w.ev_en  = 1'b1;
        w.ev_dir = DIR_S;
        w.rd_dir = DIR_E;
      end
      UA_EV_E: begin
        w.ev_en  = 1'b1;
        w.ev_dir = DIR_E;
        w.rd_dir = DIR_N;
      end
      UA_EV_N: begin
        w.ev_en  = 1'b1;
        w.ev_dir = DIR_N;
        w.rd_dir = DIR_W;
      end
      UA_EV_W: begin
        w.ev_en  = 1'b1;
        w.ev_dir = DIR_W;
      end
      UA_EMIT: begin
        w.emit = 1'b1;
        w.jmp  = JMP_EMIT;
      end
      default: begin
        w.jmp    = JMP_GOTO;
        w.target = UA_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mbfs_if.sv =====
// Request channel interfaces: commands in, flood results out.
`default_nettype none

interface mbfs_in_if;
  import mbfs_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  row;
  logic [POS_W-1:0]  col;
  logic [WALL_W-1:0] walls;

  modport source (output valid, output mode, output row, output col, output walls,
                  input ready);
  modport sink   (input valid, input mode, input row, input col, input walls,
                  output ready);
endinterface

interface mbfs_out_if;
  import mbfs_pkg::*;
  logic              valid;
  logic              ready;
  logic              expanded;
  logic [POS_W-1:0]  cell_row;
  logic [POS_W-1:0]  cell_col;
  logic [WALL_W-1:0] cell_walls;
  logic [FROM_W-1:0] arrived_from;
  logic [CNT_W-1:0]  pushed_count;
  logic              queue_empty;

  modport source (output valid, output expanded, output cell_row, output cell_col,
                  output cell_walls, output arrived_from, output pushed_count,
                  output queue_empty, input ready);
  modport sink   (input valid, input expanded, input cell_row, input cell_col,
                  input cell_walls, input arrived_from, input pushed_count,
                  input queue_empty, output ready);
endinterface

`default_nettype wire

// ===== sv/mbfs_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`default_nettype none

module mbfs_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/mbfs_useq.sv =====
// Microprogram sequencer: step counter, control store and jump logic.
`default_nettype none

module mbfs_useq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [mbfs_pkg::MODE_W-1:0] in_mode,
  input  wire mbfs_pkg::mbfs_stat_t       st,
  output      mbfs_pkg::mbfs_ctl_t        ctl
);
  import mbfs_pkg::*;

  upc_t     upc_r;
  upc_t     upc_nxt;
  mbfs_cw_t cw;
  logic     take;

  assign cw = ucode_rom(upc_r);

  always_comb begin
    upc_nxt = upc_t'(upc_r + 1'b1);
    take    = 1'b0;
    case (cw.jmp)
      JMP_NEXT: begin
        upc_nxt = upc_t'(upc_r + 1'b1);
      end
      JMP_GOTO: begin
        upc_nxt = cw.target;
      end
      JMP_DISPATCH: begin
        if (in_valid) begin
          take = 1'b1;
          case (mode_t'(in_mode))
            MODE_LOAD:  upc_nxt = UA_LOAD;
            MODE_START: upc_nxt = UA_CLR;
            MODE_STEP:  upc_nxt = UA_STEP;
            default:    upc_nxt = UA_EMIT;
          endcase
        end else begin
          upc_nxt = upc_r;
        end
      end
      JMP_IF_EMPTY: begin
        if (st.q_empty) begin
          upc_nxt = cw.target;
        end
      end
      JMP_SWEEP: begin
        if (!st.sweep_last) begin
          upc_nxt = upc_r;
        end else if (st.wipe) begin
          upc_nxt = UA_IDLE;
        end
      end
      JMP_EMIT: begin
        upc_nxt = st.can_emit ? UA_IDLE : upc_r;
      end
      default: begin
        upc_nxt = UA_IDLE;
      end
    endcase
  end

  // Come out of reset in the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_CLR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign ctl.cw   = cw;
  assign ctl.take = take;
  assign ctl.idle = (cw.jmp == JMP_DISPATCH);

endmodule

`default_nettype wire

// ===== sv/mbfs_dpath.sv =====
// Flood datapath: wall, mark and queue memories, queue pointers, result register.
`default_nettype none

module mbfs_dpath #(
  parameter int GRID_ROWS = mbfs_pkg::ROWS_DEF,
  parameter int GRID_COLS = mbfs_pkg::COLS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire mbfs_pkg::mbfs_ctl_t        ctl,
  input  wire logic [mbfs_pkg::POS_W-1:0]  in_row,
  input  wire logic [mbfs_pkg::POS_W-1:0]  in_col,
  input  wire logic [mbfs_pkg::WALL_W-1:0] in_walls,
  input  wire logic                       out_ready,
  output      logic                       out_valid,
  output      mbfs_pkg::mbfs_res_t        res,
  output      mbfs_pkg::mbfs_stat_t       st
);
  import mbfs_pkg::*;

  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int RW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int IW    = $clog2(CELLS);
  localparam int CTW   = IW + 1;
  localparam int QW    = RW + CW + FROM_W;

  mbfs_cw_t cw;
  assign cw = ctl.cw;

  // Control registers
  logic [IW-1:0]  sweep_r, sweep_nxt;
  logic           wipe_r, wipe_nxt;
  logic [IW-1:0]  head_r, head_nxt;
  logic [CTW-1:0] count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Payload registers
  logic [POS_W-1:0]  ld_row_r, ld_row_nxt;
  logic [POS_W-1:0]  ld_col_r, ld_col_nxt;
  logic [WALL_W-1:0] ld_walls_r, ld_walls_nxt;
  logic [RW-1:0]     cur_row_r, cur_row_nxt;
  logic [CW-1:0]     cur_col_r, cur_col_nxt;
  logic [FROM_W-1:0] cur_from_r, cur_from_nxt;
  logic [WALL_W-1:0] cur_walls_r, cur_walls_nxt;
  logic              expanded_r, expanded_nxt;
  logic [CNT_W-1:0]  pushed_r, pushed_nxt;
  mbfs_res_t         res_r, res_nxt;

  // Memory ports
  logic              wall_we, vis_we, q_we;
  logic [IW-1:0]     wall_waddr, wall_raddr, vis_waddr, vis_raddr, q_waddr;
  logic [WALL_W-1:0] wall_wdata, wall_rdata;
  logic              vis_wdata, vis_rdata;
  logic [QW-1:0]     q_wdata, q_rdata;

  function automatic logic [IW-1:0] cell_idx(logic [RW-1:0] r, logic [CW-1:0] c);
    return IW'(IW'(r) * IW'(GRID_COLS) + IW'(c));
  endfunction

  function automatic logic [RW+CW-1:0] nb_pos(dir_t d, logic [RW-1:0] r,
                                             logic [CW-1:0] c);
    logic [RW+CW-1:0] p;
    case (d)
      DIR_S:   p = {RW'(r + 1'b1), c};
      DIR_E:   p = {r, CW'(c + 1'b1)};
      DIR_N:   p = {RW'(r - 1'b1), c};
      default: p = {r, CW'(c - 1'b1)};
    endcase
    return p;
  endfunction

  // No move leaves the grid; a wall on that side blocks it
  function automatic logic nb_open(dir_t d, logic [RW-1:0] r, logic [CW-1:0] c,
                                   logic [WALL_W-1:0] w);
    logic edge_ok;
    case (d)
      DIR_S:   edge_ok = (r != RW'(GRID_ROWS - 1));
      DIR_E:   edge_ok = (c != CW'(GRID_COLS - 1));
      DIR_N:   edge_ok = (r != '0);
      default: edge_ok = (c != '0);
    endcase
    return edge_ok && !w[dir_wall_bit(d)];
  endfunction

  logic              in_inside;
  logic [RW-1:0]     ld_r;
  logic [CW-1:0]     ld_c;
  logic              sweep_last;
  logic              q_full;
  logic [CTW-1:0]    tail_sum;
  logic [IW-1:0]     tail;
  logic [IW-1:0]     head_inc;
  logic [RW+CW-1:0]  rd_pos, ev_pos;
  logic [RW-1:0]     ev_row;
  logic [CW-1:0]     ev_col;
  logic              push;
  logic              seed_push;
  logic              can_emit;
  logic [RW-1:0]     q_row;
  logic [CW-1:0]     q_col;

  assign in_inside  = (int'(ld_row_r) < GRID_ROWS) && (int'(ld_col_r) < GRID_COLS);
  assign ld_r       = RW'(ld_row_r);
  assign ld_c       = CW'(ld_col_r);
  assign sweep_last = (sweep_r == IW'(CELLS - 1));
  assign q_full     = (count_r == CTW'(CELLS));
  assign tail_sum   = CTW'(head_r) + count_r;
  assign tail       = (tail_sum >= CTW'(CELLS)) ? IW'(tail_sum - CTW'(CELLS))
                                                : IW'(tail_sum);
  assign head_inc   = (head_r == IW'(CELLS - 1)) ? '0 : IW'(head_r + 1'b1);
  assign rd_pos     = nb_pos(cw.rd_dir, cur_row_r, cur_col_r);
  assign ev_pos     = nb_pos(cw.ev_dir, cur_row_r, cur_col_r);
  assign ev_row     = ev_pos[RW+CW-1:CW];
  assign ev_col     = ev_pos[CW-1:0];
  assign push       = cw.ev_en && nb_open(cw.ev_dir, cur_row_r, cur_col_r, cur_walls_r)
                      && !vis_rdata && !q_full;
  assign seed_push  = cw.seed && in_inside && !q_full;
  assign can_emit   = !out_valid_r || out_ready;
  assign q_row      = q_rdata[QW-1 -: RW];
  assign q_col      = q_rdata[FROM_W +: CW];

  // Memory port steering
  always_comb begin
    wall_we    = 1'b0;
    wall_waddr = cell_idx(ld_r, ld_c);
    wall_wdata = ld_walls_r;
    if (cw.wr_load && in_inside) begin
      wall_we = 1'b1;
    end else if (cw.sweep && wipe_r) begin
      wall_we    = 1'b1;
      wall_waddr = sweep_r;
      wall_wdata = '0;
    end
    wall_raddr = cell_idx(q_row, q_col);

    vis_we    = 1'b0;
    vis_waddr = sweep_r;
    vis_wdata = 1'b0;
    if (cw.sweep) begin
      vis_we = 1'b1;
    end else if (cw.pop) begin
      vis_we    = 1'b1;
      vis_waddr = cell_idx(q_row, q_col);
      vis_wdata = 1'b1;
    end else if (push) begin
      vis_we    = 1'b1;
      vis_waddr = cell_idx(ev_row, ev_col);
      vis_wdata = 1'b1;
    end
    vis_raddr = cell_idx(rd_pos[RW+CW-1:CW], rd_pos[CW-1:0]);

    q_we    = seed_push || push;
    q_waddr = tail;
    q_wdata = push ? {ev_row, ev_col, dir_from(cw.ev_dir)} : {ld_r, ld_c, FROM_SEED};
  end

  // Next-state logic
  always_comb begin
    sweep_nxt     = sweep_r;
    wipe_nxt      = wipe_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    ld_row_nxt    = ld_row_r;
    ld_col_nxt    = ld_col_r;
    ld_walls_nxt  = ld_walls_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    cur_from_nxt  = cur_from_r;
    cur_walls_nxt = cur_walls_r;
    expanded_nxt  = expanded_r;
    pushed_nxt    = pushed_r;
    res_nxt       = res_r;

    if (ctl.take) begin
      ld_row_nxt   = in_row;
      ld_col_nxt   = in_col;
      ld_walls_nxt = in_walls;
      expanded_nxt = 1'b0;
      pushed_nxt   = '0;
    end
    if (cw.sweep) begin
      sweep_nxt = sweep_last ? '0 : IW'(sweep_r + 1'b1);
      if (sweep_last) begin
        wipe_nxt = 1'b0;
      end
    end
    if (cw.q_clr) begin
      head_nxt  = '0;
      count_nxt = '0;
    end
    if (seed_push || push) begin
      count_nxt = CTW'(count_r + 1'b1);
    end
    if (push) begin
      pushed_nxt = CNT_W'(pushed_r + 1'b1);
    end
    if (cw.pop) begin
      cur_row_nxt  = q_row;
      cur_col_nxt  = q_col;
      cur_from_nxt = q_rdata[FROM_W-1:0];
      head_nxt     = head_inc;
      count_nxt    = CTW'(count_r - 1'b1);
      expanded_nxt = 1'b1;
    end
    if (cw.lat_walls) begin
      cur_walls_nxt = wall_rdata;
    end

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cw.emit && can_emit) begin
      out_valid_nxt        = 1'b1;
      res_nxt.expanded     = expanded_r;
      res_nxt.cell_row     = expanded_r ? POS_W'(cur_row_r) : '0;
      res_nxt.cell_col     = expanded_r ? POS_W'(cur_col_r) : '0;
      res_nxt.cell_walls   = expanded_r ? cur_walls_r : '0;
      res_nxt.arrived_from = expanded_r ? cur_from_r : FROM_SEED;
      res_nxt.pushed_count = expanded_r ? pushed_r : '0;
      res_nxt.queue_empty  = (count_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      wipe_r      <= 1'b1;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sweep_r     <= sweep_nxt;
      wipe_r      <= wipe_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_row_r    <= ld_row_nxt;
    ld_col_r    <= ld_col_nxt;
    ld_walls_r  <= ld_walls_nxt;
    cur_row_r   <= cur_row_nxt;
    cur_col_r   <= cur_col_nxt;
    cur_from_r  <= cur_from_nxt;
    cur_walls_r <= cur_walls_nxt;
    expanded_r  <= expanded_nxt;
    pushed_r    <= pushed_nxt;
    res_r       <= res_nxt;
  end

  mbfs_ram #(.WIDTH(WALL_W), .DEPTH(CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (wall_we),
    .waddr (wall_waddr),
    .wdata (wall_wdata),
    .raddr (wall_raddr),
    .rdata (wall_rdata)
  );

  mbfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  mbfs_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (head_r),
    .rdata (q_rdata)
  );

  assign st.q_empty    = (count_r == '0);
  assign st.sweep_last = sweep_last;
  assign st.wipe       = wipe_r;
  assign st.can_emit   = can_emit;

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== sv/maze_bfs_flood_step.sv =====
// Top level of the breadth-first maze flood: sequencer plus datapath.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------------
//   in_if   | in  | valid/ready        | mode, row, col, walls
//   out_if  | out | valid/ready        | expanded, cell_row, cell_col, cell_walls,
//           |     |                    | arrived_from, pushed_count, queue_empty
//
// Each request is handled alone by a microprogram. A step request reads the queue head,
// then the walls, then one visited mark per neighbor on the single read port of the mark
// memory before its result reaches the result register; a load, a step on an empty queue
// and an unused mode go straight to the result, and a start first sweeps all marks.
// After reset the same sweep clears walls and marks, with in_if.ready low.
// The program returns to its dispatch step before it takes the next request; a stalled
// result holds in the output register while the next request runs, and that request's result waits.
`default_nettype none

module maze_bfs_flood_step #(
  parameter int GRID_ROWS = mbfs_pkg::ROWS_DEF,
  parameter int GRID_COLS = mbfs_pkg::COLS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  mbfs_in_if.sink   in_if,
  mbfs_out_if.source out_if
);
  import mbfs_pkg::*;

  mbfs_ctl_t  ctl;
  mbfs_stat_t st;
  mbfs_res_t  res;
  logic       out_valid;

  // Step counter and control store
  mbfs_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .st       (st),
    .ctl      (ctl)
  );

  // Memories, queue pointers and the result register
  mbfs_dpath #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_row    (in_if.row),
    .in_col    (in_if.col),
    .in_walls  (in_if.walls),
    .out_ready (out_if.ready),
    .out_valid (out_valid),
    .res       (res),
    .st        (st)
  );

  // Take a request only while the program waits at its dispatch step
  assign in_if.ready = ctl.idle;

  assign out_if.valid        = out_valid;
  assign out_if.expanded     = res.expanded;
  assign out_if.cell_row     = res.cell_row;
  assign out_if.cell_col     = res.cell_col;
  assign out_if.cell_walls   = res.cell_walls;
  assign out_if.arrived_from = res.arrived_from;
  assign out_if.pushed_count = res.pushed_count;
  assign out_if.queue_empty  = res.queue_empty;

endmodule

`default_nettype wire

// ===== dv/maze_bfs_flood_step_test.sv =====
// Self-checking testbench for the breadth-first maze flood block.
module maze_bfs_flood_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mbfs_pkg::*;

  localparam int CELLS          = ROWS_DEF * COLS_DEF;
  localparam int DIRECTED_N     = 25;
  localparam int RANDOM_ITEMS   = 800;
  localparam int QUIET_TAIL     = 100;   // requests at the end with no idling at all
  localparam int WATCHDOG_LIMIT = 2000;  // covers the reset sweep and a start sweep
  localparam int DRAIN_TAIL     = 20;

  // Mode code with no meaning for the block; it must be answered and ignored.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam mbfs_res_t NO_CHECK = '0;

  // One queued frontier cell of the shadow flood.
  typedef struct packed {
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [FROM_W-1:0] arrival;
  } frontier_t;

  // One row of the directed table. Where typed is set, want is the result
  // worked out by hand; otherwise the shadow flood supplies it.
  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [WALL_W-1:0] walls;
    bit                typed;
    mbfs_res_t         want;
  } flood_row_t;

  logic clk;
  logic rst_n;

  mbfs_in_if  in_if ();
  mbfs_out_if out_if ();

  maze_bfs_flood_step uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // Shadow copy of the block's state.
  bit [WALL_W-1:0] maze_walls [CELLS];
  bit              cell_seen  [CELLS];
  frontier_t       frontier   [CELLS];
  int unsigned     frontier_head;
  int unsigned     frontier_count;

  // Results owed by the block, oldest first.
  mbfs_res_t flood_results_due [$];

  flood_row_t directed_rows [DIRECTED_N];

  // Idling controls of the request and result sides.
  int gap_pct;
  int stall_pct;
  bit quiet;

  int errors;
  int results_checked;
  int items_sent;
  int loads_sent, starts_sent, steps_sent, unused_sent, cells_expanded;
  int rounds;
  int watch_cycles;

  // Clock: 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int cell_at(int r, int c);
    return r * COLS_DEF + c;
  endfunction

  function automatic mbfs_res_t res_of(bit x, int r, int c, int w, logic [FROM_W-1:0] f,
                                       int n, bit qe);
    mbfs_res_t res;
    res.expanded     = x;
    res.cell_row     = r[POS_W-1:0];
    res.cell_col     = c[POS_W-1:0];
    res.cell_walls   = w[WALL_W-1:0];
    res.arrived_from = f;
    res.pushed_count = n[CNT_W-1:0];
    res.queue_empty  = qe;
    return res;
  endfunction

  // Append a cell to the frontier; drop it if the frontier is full.
  function automatic bit frontier_push(int r, int c, logic [FROM_W-1:0] f);
    int unsigned tail;
    if (frontier_count >= CELLS) return 1'b0;
    tail = (frontier_head + frontier_count) % CELLS;
    frontier[tail].row     = r[POS_W-1:0];
    frontier[tail].col     = c[POS_W-1:0];
    frontier[tail].arrival = f;
    frontier_count++;
    return 1'b1;
  endfunction

  // Queue a neighbor unless already seen; mark it seen once queued.
  function automatic int visit_neighbor(int r, int c, logic [FROM_W-1:0] f);
    if (cell_seen[cell_at(r, c)]) return 0;
    if (!frontier_push(r, c, f)) return 0;
    cell_seen[cell_at(r, c)] = 1'b1;
    return 1;
  endfunction

  // Advance the shadow flood by one request and return the result it owes.
  function automatic mbfs_res_t flood_predict(logic [MODE_W-1:0] m, logic [POS_W-1:0] r,
                                              logic [POS_W-1:0] c, logic [WALL_W-1:0] w);
    mbfs_res_t         res;
    frontier_t         head;
    logic [WALL_W-1:0] cw;
    int                hr, hc, pushed;
    res    = '0;
    pushed = 0;
    case (m)
      MODE_LOAD: maze_walls[cell_at(int'(r), int'(c))] = w;
      MODE_START: begin
        // Start flushes the frontier and the marks; the seed itself is not
        // marked until it is popped.
        cell_seen      = '{default: 1'b0};
        frontier_head  = 0;
        frontier_count = 0;
        void'(frontier_push(int'(r), int'(c), FROM_SEED));
      end
      MODE_STEP: begin
        if (frontier_count != 0) begin
          head           = frontier[frontier_head];
          frontier_head  = (frontier_head + 1) % CELLS;
          frontier_count = frontier_count - 1;
          hr             = int'(head.row);
          hc             = int'(head.col);
          cell_seen[cell_at(hr, hc)] = 1'b1;
          cw                = maze_walls[cell_at(hr, hc)];
          res.expanded      = 1'b1;
          res.cell_row      = head.row;
          res.cell_col      = head.col;
          res.cell_walls    = cw;
          res.arrived_from  = head.arrival;
          // Neighbor order: south, east, north, west; never leave the grid.
          if (hr + 1 < ROWS_DEF && !cw[WB_S])
            pushed += visit_neighbor(hr + 1, hc, FROM_SOUTH);
          if (hc + 1 < COLS_DEF && !cw[WB_E])
            pushed += visit_neighbor(hr, hc + 1, FROM_EAST);
          if (hr > 0 && !cw[WB_N])
            pushed += visit_neighbor(hr - 1, hc, FROM_NORTH);
          if (hc > 0 && !cw[WB_W])
            pushed += visit_neighbor(hr, hc - 1, FROM_WEST);
          res.pushed_count  = pushed[CNT_W-1:0];
        end
      end
      default: ;  // unused mode: nothing moves
    endcase
    res.queue_empty = (frontier_count == 0);
    return res;
  endfunction

  // Random cell coordinate.
  function automatic logic [POS_W-1:0] pick_pos();
    return POS_W'($urandom_range(15));
  endfunction

  // Wall patterns: 0 mostly open, 1 uniform, 2 mostly closed.
  function automatic logic [WALL_W-1:0] pick_walls(int density);
    logic [WALL_W-1:0] w;
    case (density)
      0:       w = WALL_W'($urandom_range(15) & $urandom_range(15) & $urandom_range(15));
      1:       w = WALL_W'($urandom_range(15));
      default: w = WALL_W'($urandom_range(15) | $urandom_range(15));
    endcase
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Present one request and hold it until accepted; then maybe idle a burst.
  task automatic issue_request(logic [MODE_W-1:0] m, logic [POS_W-1:0] r,
                               logic [POS_W-1:0] c, logic [WALL_W-1:0] w,
                               bit typed = 1'b0, mbfs_res_t want = '0);
    mbfs_res_t predicted;
    predicted = flood_predict(m, r, c, w);
    flood_results_due.push_back(typed ? want : predicted);
    case (m)
      MODE_LOAD:  loads_sent++;
      MODE_START: starts_sent++;
      MODE_STEP:  steps_sent++;
      default:    unused_sent++;
    endcase
    if (m != MODE_UNUSED) items_sent++;
    if (predicted.expanded) cells_expanded++;
    in_if.valid <= 1'b1;
    in_if.mode  <= m;
    in_if.row   <= r;
    in_if.col   <= c;
    in_if.walls <= w;
    do @(posedge clk); while (!in_if.ready);
    if (items_sent >= DIRECTED_N + RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
    if (!quiet && gap_pct != 0 && int'($urandom_range(99)) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (flood_results_due.size() != 0) @(posedge clk);
  endtask

  // Result side: stall in random bursts.
  always @(posedge clk) begin : result_ready
    int stall_left;
    if (quiet) begin
      stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (stall_pct != 0 && int'($urandom_range(99)) < stall_pct) begin
      stall_left = int'($urandom_range(0, 8));
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare each taken result with the oldest owed one, field by field.
  always @(posedge clk) begin : result_check
    mbfs_res_t due;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (flood_results_due.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request pending, expected none, got expanded=%0d",
                 $time, out_if.expanded);
      end else begin
        due = flood_results_due.pop_front();
        results_checked++;
        check_field("expanded",     32'(due.expanded),     32'(out_if.expanded));
        check_field("cell_row",     32'(due.cell_row),     32'(out_if.cell_row));
        check_field("cell_col",     32'(due.cell_col),     32'(out_if.cell_col));
        check_field("cell_walls",   32'(due.cell_walls),   32'(out_if.cell_walls));
        check_field("arrived_from", 32'(due.arrived_from), 32'(out_if.arrived_from));
        check_field("pushed_count", 32'(due.pushed_count), 32'(out_if.pushed_count));
        check_field("queue_empty",  32'(due.queue_empty),  32'(out_if.queue_empty));
      end
    end
  end

  // Watchdog: end the run if no request or result moves for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      watch_cycles = 0;
    end else if (watch_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: timeout, nothing moved for %0d cycles, %0d results still owed",
               $time, watch_cycles, flood_results_due.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      watch_cycles++;
    end
  end

  initial begin : stimulus
    int density, step_cap, pick, empties;
    // Drive every request input to a known value before the first edge.
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.mode   <= MODE_LOAD;
    in_if.row    <= '0;
    in_if.col    <= '0;
    in_if.walls  <= '0;
    gap_pct      = 0;
    stall_pct    = 0;
    quiet        = 1'b0;
    watch_cycles = 0;

    // Directed table: corners, full and empty walls, every mode, every arrival move.
    directed_rows = '{
      // step on an empty queue right after reset
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 1)},
      // unused mode: ignored
      '{MODE_UNUSED, 4'd5,  4'd9,  4'hF, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 1)},
      '{MODE_LOAD,   4'd15, 4'd15, 4'hF, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 1)},
      '{MODE_LOAD,   4'd0,  4'd15, 4'h5, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 1)},
      '{MODE_LOAD,   4'd15, 4'd0,  4'hA, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 1)},
      '{MODE_LOAD,   4'd7,  4'd8,  4'h0, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 1)},
      // boxed-in far corner: expands, pushes nothing, queue runs dry
      '{MODE_START,  4'd15, 4'd15, 4'h0, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b1, res_of(1, 15, 15, 15, FROM_SEED, 0, 1)},
      '{MODE_STEP,   4'd15, 4'd15, 4'hF, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 1)},
      // open origin corner: only south and east stay on the grid
      '{MODE_START,  4'd0,  4'd0,  4'hF, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b1, res_of(1, 0, 0, 0, FROM_SEED, 2, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b0, NO_CHECK},
      // walls change under a running search
      '{MODE_LOAD,   4'd0,  4'd1,  4'h4, 1'b0, NO_CHECK},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b0, NO_CHECK},
      '{MODE_UNUSED, 4'd15, 4'd0,  4'h0, 1'b0, NO_CHECK},
      // restart mid-search from an open interior cell: all four pushed
      '{MODE_START,  4'd7,  4'd8,  4'h0, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b1, res_of(1, 7, 8, 0, FROM_SEED, 4, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b0, NO_CHECK},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b0, NO_CHECK},
      // top-right corner walled north and south: only west is open
      '{MODE_START,  4'd0,  4'd15, 4'h0, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b1, res_of(1, 0, 15, 5, FROM_SEED, 1, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b0, NO_CHECK},
      // bottom-left corner walled east and west: only north is open
      '{MODE_START,  4'd15, 4'd0,  4'h0, 1'b1, res_of(0, 0, 0, 0, FROM_SEED, 0, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b1, res_of(1, 15, 0, 10, FROM_SEED, 1, 0)},
      '{MODE_STEP,   4'd0,  4'd0,  4'h0, 1'b0, NO_CHECK}
    };

    // Hold reset low at the start, then release it for good.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (directed_rows[i])
      issue_request(directed_rows[i].mode, directed_rows[i].row, directed_rows[i].col,
                    directed_rows[i].walls, directed_rows[i].typed, directed_rows[i].want);

    // Random rounds: patch some walls, seed a search, then walk it with steps.
    // A little noise (loads, restarts, unused codes) lands inside the walk.
    while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
      rounds++;
      case (rounds % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 25; stall_pct = 25; end
        2:       begin gap_pct = 50; stall_pct = 10; end
        default: begin gap_pct = 10; stall_pct = 50; end
      endcase
      density = int'($urandom_range(2));
      repeat ($urandom_range(4, 30))
        issue_request(MODE_LOAD, pick_pos(), pick_pos(), pick_walls(density));
      issue_request(MODE_START, pick_pos(), pick_pos(), WALL_W'($urandom_range(15)));
      // A third of the rounds flood until the frontier runs dry.
      step_cap = ($urandom_range(2) == 0) ? 300 : int'($urandom_range(1, 60));
      empties  = 0;
      for (int s = 0; s < step_cap; s++) begin
        pick = int'($urandom_range(99));
        if (pick < 5)
          issue_request(MODE_LOAD, pick_pos(), pick_pos(), pick_walls(density));
        else if (pick < 7)
          issue_request(MODE_UNUSED, pick_pos(), pick_pos(), WALL_W'($urandom_range(15)));
        else if (pick < 8)
          issue_request(MODE_START, pick_pos(), pick_pos(), WALL_W'($urandom_range(15)));
        else
          issue_request(MODE_STEP, pick_pos(), pick_pos(), WALL_W'($urandom_range(15)));
        if (frontier_count == 0) empties++;
        if (empties == 2) break;
        if (items_sent >= DIRECTED_N + RANDOM_ITEMS) break;
      end
      // Hold the sender off until the block has caught up, always on round one.
      if (rounds == 1 || $urandom_range(2) == 0) drain_results();
    end

    // Finish: no idling, wait out every owed result, then a short tail.
    quiet = 1'b1;
    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Sent %0d loads, %0d starts, %0d steps (%0d cells expanded), %0d unused codes",
             loads_sent, starts_sent, steps_sent, cells_expanded, unused_sent);
    $display("Checked %0d results over %0d random rounds, %0d mismatches",
             results_checked, rounds, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
